### hw/rtl/rdt_pkg.sv
// Shared types, codes and defaults for the reliable delivery tracker.
package rdt_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int ACK_DEPTH_DEF     = 16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    localparam logic [2:0] OP_SEND  = 3'd0;
    localparam logic [2:0] OP_RECV  = 3'd1;
    localparam logic [2:0] OP_DRAIN = 3'd2;
    localparam logic [2:0] OP_ACK   = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    localparam logic [2:0] KIND_SENT     = 3'd0;
    localparam logic [2:0] KIND_RECEIVED = 3'd1;
    localparam logic [2:0] KIND_ACK_ENT  = 3'd2;
    localparam logic [2:0] KIND_ACKED    = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd4;
    localparam logic [2:0] KIND_NOTHING  = 3'd5;

    localparam logic [3:0] ACT_NONE     = 4'd0;
    localparam logic [3:0] ACT_SEND     = 4'd1;
    localparam logic [3:0] ACT_RECV     = 4'd2;
    localparam logic [3:0] ACT_NOTHING  = 4'd3;
    localparam logic [3:0] ACT_CLEAR    = 4'd4;
    localparam logic [3:0] ACT_ACK_MISS = 4'd5;
    localparam logic [3:0] ACT_ACK_HIT  = 4'd6;
    localparam logic [3:0] ACT_DRAIN    = 4'd7;
    localparam logic [3:0] ACT_TIMEOUT  = 4'd8;

    typedef struct packed {
        logic       latch;
        logic [3:0] act;
        logic       last;
        logic [4:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       pend_end;
        logic       ack_empty;
        logic       ack_last;
        logic       match;
        logic       expired;
    } t_stat;

endpackage

### hw/rtl/rdt_ctrl.sv
// Sequencer for the tracker: dispatch, table walks and result pacing.
module rdt_ctrl
    import rdt_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int IW            = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_stat         i_stat,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_idx
);
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_ACK_SCAN = 3'd2;
    localparam logic [2:0] S_DRAIN    = 3'd3;
    localparam logic [2:0] S_TO_COUNT = 3'd4;
    localparam logic [2:0] S_TO_EMIT  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_rem, n_rem;
    t_cmd          cmd;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        cmd     = '0;
        cmd.cnt = 5'(r_cnt);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_idx   = '0;
                n_cnt   = '0;
                n_state = S_IDLE;
                cmd.last = 1'b1;
                unique case (i_stat.op)
                    OP_SEND:  cmd.act = ACT_SEND;
                    OP_RECV:  cmd.act = ACT_RECV;
                    OP_CLEAR: cmd.act = ACT_CLEAR;
                    OP_DRAIN: begin
                        if (i_stat.ack_empty) cmd.act = ACT_NOTHING;
                        else n_state = S_DRAIN;
                    end
                    OP_ACK:  n_state = S_ACK_SCAN;
                    OP_TICK: n_state = S_TO_COUNT;
                    default: cmd.act = ACT_NOTHING;
                endcase
            end
            S_ACK_SCAN: begin
                cmd.last = 1'b1;
                if (i_stat.pend_end) begin
                    cmd.act = ACT_ACK_MISS;
                    n_state = S_IDLE;
                end else if (i_stat.match) begin
                    cmd.act = ACT_ACK_HIT;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                cmd.act  = ACT_DRAIN;
                cmd.last = i_stat.ack_last;
                if (i_stat.ack_last) n_state = S_IDLE;
                else n_idx = r_idx + 1'b1;
            end
            S_TO_COUNT: begin
                if (i_stat.pend_end) begin
                    n_idx = '0;
                    n_rem = r_cnt;
                    if (r_cnt == '0) begin
                        cmd.act  = ACT_NOTHING;
                        cmd.last = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_TO_EMIT;
                    end
                end else begin
                    if (i_stat.expired) n_cnt = r_cnt + 1'b1;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TO_EMIT: begin
                if (i_stat.pend_end) begin
                    n_state = S_IDLE;
                end else if (i_stat.expired) begin
                    // entry removed, next one slides into this slot
                    cmd.act  = ACT_TIMEOUT;
                    cmd.last = (r_rem == CW'(1));
                    n_rem    = r_rem - 1'b1;
                    if (r_rem == CW'(1)) n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = cmd;
    assign o_idx = r_idx;
endmodule

### hw/rtl/rdt_dp.sv
// Tracker datapath: counters, pending table, ack queue and result registers.
module rdt_dp
    import rdt_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int ACK_DEPTH     = ACK_DEPTH_DEF,
    parameter int IW            = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_operation,
    input  logic [31:0]   i_seq_number,
    input  logic [31:0]   i_now,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_idx,
    output t_stat         o_stat,
    output logic          o_result_strobe,
    output logic [2:0]    o_result_kind,
    output logic [31:0]   o_seq_out,
    output logic          o_in_order,
    output logic          o_ack_hit,
    output logic          o_overflow,
    output logic [4:0]    o_entry_count,
    output logic          o_last
);
    localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int AIW = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int ACW = $clog2(ACK_DEPTH + 1);

    logic [31:0]  r_timeout;
    logic [31:0]  r_next_out, r_next_in;
    logic [2:0]   r_op;
    logic [31:0]  r_seq, r_now;
    logic [31:0]  r_pend_seq  [PENDING_DEPTH];
    logic [31:0]  r_pend_time [PENDING_DEPTH];
    logic [PCW-1:0] r_pend_cnt;
    logic [31:0]  r_ackq [ACK_DEPTH];
    logic [ACW-1:0] r_ack_fill;

    logic [PIW-1:0] pidx;
    logic [AIW-1:0] aidx;
    logic [31:0]    cur_seq, cur_time, cur_ack;
    logic           pend_full, ack_full, in_order;

    assign pidx      = i_idx[PIW-1:0];
    assign aidx      = i_idx[AIW-1:0];
    assign cur_seq   = r_pend_seq[pidx];
    assign cur_time  = r_pend_time[pidx];
    assign cur_ack   = r_ackq[aidx];
    assign pend_full = (r_pend_cnt == PCW'(PENDING_DEPTH));
    assign ack_full  = (r_ack_fill == ACW'(ACK_DEPTH));
    assign in_order  = (r_seq == r_next_in);

    always_comb begin
        o_stat.op        = r_op;
        o_stat.pend_end  = (i_idx == IW'(r_pend_cnt));
        o_stat.ack_empty = (r_ack_fill == '0);
        o_stat.ack_last  = ((i_idx + 1'b1) == IW'(r_ack_fill));
        o_stat.match     = (cur_seq == r_seq);
        o_stat.expired   = ((r_now - cur_time) >= r_timeout);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_next_out <= '0;
            r_next_in  <= '0;
            r_pend_cnt <= '0;
            r_ack_fill <= '0;
            r_op       <= '0;
        end else begin
            if (i_cfg_we) r_timeout <= i_cfg_wdata;
            if (i_cmd.latch) r_op <= i_operation;
            unique case (i_cmd.act)
                ACT_SEND: begin
                    r_next_out <= r_next_out + 1'b1;
                    if (!pend_full) r_pend_cnt <= r_pend_cnt + 1'b1;
                end
                ACT_RECV: begin
                    if (in_order) r_next_in <= r_next_in + 1'b1;
                    if (!ack_full) r_ack_fill <= r_ack_fill + 1'b1;
                end
                ACT_CLEAR: begin
                    r_next_out <= '0;
                    r_next_in  <= '0;
                    r_pend_cnt <= '0;
                    r_ack_fill <= '0;
                end
                ACT_ACK_HIT, ACT_TIMEOUT: r_pend_cnt <= r_pend_cnt - 1'b1;
                ACT_DRAIN: if (o_stat.ack_last) r_ack_fill <= '0;
                default: ;
            endcase
        end
    end

    // table and queue storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_seq <= i_seq_number;
            r_now <= i_now;
        end
        if (i_cmd.act == ACT_SEND && !pend_full) begin
            r_pend_seq[r_pend_cnt[PIW-1:0]]  <= r_next_out;
            r_pend_time[r_pend_cnt[PIW-1:0]] <= r_now;
        end
        if (i_cmd.act == ACT_ACK_HIT || i_cmd.act == ACT_TIMEOUT) begin
            for (int j = 0; j < PENDING_DEPTH - 1; j++) begin
                if (PIW'(j) >= pidx) begin
                    r_pend_seq[j]  <= r_pend_seq[j + 1];
                    r_pend_time[j] <= r_pend_time[j + 1];
                end
            end
        end
        if (i_cmd.act == ACT_RECV && !ack_full) begin
            r_ackq[r_ack_fill[AIW-1:0]] <= r_seq;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= (i_cmd.act != ACT_NONE && i_cmd.act != ACT_CLEAR) ||
                               (i_cmd.act == ACT_CLEAR);
        end
    end

    always_ff @(posedge i_clk) begin
        o_last        <= i_cmd.last;
        o_in_order    <= 1'b0;
        o_ack_hit     <= 1'b0;
        o_overflow    <= 1'b0;
        o_entry_count <= '0;
        o_seq_out     <= '0;
        o_result_kind <= KIND_NOTHING;
        unique case (i_cmd.act)
            ACT_SEND: begin
                o_result_kind <= KIND_SENT;
                o_seq_out     <= r_next_out;
                o_overflow    <= pend_full;
            end
            ACT_RECV: begin
                o_result_kind <= KIND_RECEIVED;
                o_seq_out     <= r_seq;
                o_in_order    <= in_order;
                o_overflow    <= ack_full;
            end
            ACT_ACK_MISS: begin
                o_result_kind <= KIND_ACKED;
                o_seq_out     <= r_seq;
            end
            ACT_ACK_HIT: begin
                o_result_kind <= KIND_ACKED;
                o_seq_out     <= r_seq;
                o_ack_hit     <= 1'b1;
            end
            ACT_DRAIN: begin
                o_result_kind <= KIND_ACK_ENT;
                o_seq_out     <= cur_ack;
                o_entry_count <= 5'(r_ack_fill);
            end
            ACT_TIMEOUT: begin
                o_result_kind <= KIND_TIMEOUT;
                o_seq_out     <= cur_seq;
                o_entry_count <= i_cmd.cnt;
            end
            default: ;
        endcase
    end
endmodule

### hw/rtl/reliable_delivery_tracker.sv
// Send, receive and clear issue one result beat from the dispatch state; ack walks the pending entries.
// Tick scan: one pass counting expired entries, then a second pass emitting them.
// Drain: one result beat per queued ack each cycle.
// One item at a time; busy stays high until the final beat has been issued.
// Synchronous active-low reset clears counters and fill levels and sets the timeout to 1000.
module reliable_delivery_tracker
    import rdt_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int ACK_DEPTH     = ACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_now,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_result_strobe,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_seq_out,
    output logic        o_in_order,
    output logic        o_ack_hit,
    output logic        o_overflow,
    output logic [4:0]  o_entry_count,
    output logic        o_last
);
    localparam int MAXD = (PENDING_DEPTH > ACK_DEPTH) ? PENDING_DEPTH : ACK_DEPTH;
    localparam int IW   = $clog2(MAXD + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [IW-1:0] idx;

    rdt_ctrl #(
        .PENDING_DEPTH(PENDING_DEPTH),
        .IW(IW)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_idx  (idx)
    );

    rdt_dp #(
        .PENDING_DEPTH(PENDING_DEPTH),
        .ACK_DEPTH(ACK_DEPTH),
        .IW(IW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (i_operation),
        .i_seq_number   (i_seq_number),
        .i_now          (i_now),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .i_idx          (idx),
        .o_stat         (stat),
        .o_result_strobe(o_result_strobe),
        .o_result_kind  (o_result_kind),
        .o_seq_out      (o_seq_out),
        .o_in_order     (o_in_order),
        .o_ack_hit      (o_ack_hit),
        .o_overflow     (o_overflow),
        .o_entry_count  (o_entry_count),
        .o_last         (o_last)
    );
endmodule

### hw/rtl/rdt_checker.sv
// Port-level checks for the tracker, bound to the top level.
module rdt_port_checks
    import rdt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_strobe,
    input logic [2:0]  o_result_kind,
    input logic [31:0] o_seq_out,
    input logic        o_last
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_more_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_last |-> busy)
        else $error("non-final beat while idle");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> o_result_kind == KIND_SENT || o_result_kind == KIND_RECEIVED ||
            o_result_kind == KIND_ACK_ENT || o_result_kind == KIND_ACKED ||
            o_result_kind == KIND_TIMEOUT || o_result_kind == KIND_NOTHING)
        else $error("bad result kind");

    a_nothing_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_result_kind == KIND_NOTHING |-> o_last && o_seq_out == '0)
        else $error("empty result malformed");
endmodule

bind reliable_delivery_tracker rdt_port_checks u_rdt_port_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_strobe(o_result_strobe),
    .o_result_kind  (o_result_kind),
    .o_seq_out      (o_seq_out),
    .o_last         (o_last)
);
